@@ design/ihex_pkg.sv @@
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types and codes of the hex record parser: character classes,
// queue item layout, parse phases, result kinds, error codes and record types.
// ----------------------------------------------------------------------------
package ihex_pkg;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = 1;
    localparam int QCNT_W  = 2;

    typedef enum logic [1:0] {
        CLS_COLON,
        CLS_HEX,
        CLS_OTHER
    } char_class_t;

    typedef struct packed {
        char_class_t cls;
        logic [3:0]  digit;
    } q_item_t;

    typedef enum logic [2:0] {
        PH_COLON,
        PH_COUNT,
        PH_ADDR,
        PH_TYPE,
        PH_DATA,
        PH_PAY_A,
        PH_PAY_B,
        PH_CSUM
    } phase_t;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_COLON    = 3'd0;
    localparam logic [2:0] ERR_NONHEX   = 3'd1;
    localparam logic [2:0] ERR_LIMIT    = 3'd2;
    localparam logic [2:0] ERR_TYPE     = 3'd3;
    localparam logic [2:0] ERR_CHECKSUM = 3'd4;

    localparam logic [7:0] REC_DATA    = 8'd0;
    localparam logic [7:0] REC_EOF     = 8'd1;
    localparam logic [7:0] REC_SEGMENT = 8'd2;
    localparam logic [7:0] REC_SEG_START = 8'd3;
    localparam logic [7:0] REC_LINEAR  = 8'd4;
    localparam logic [7:0] REC_LIN_START = 8'd5;

endpackage

@@ design/intel_hex_record_parser_unit.sv @@
// ----------------------------------------------------------------------------
// intel_hex_record_parser_unit
// Character-stream hex record parser producing memory writes, end-of-file
// summary and error items.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid, in_stall, char_in) carries one ASCII character
//   per item. Output channel (out_valid, out_stall, result fields) carries a
//   memory write, an end-of-file item with start address and extent, or an
//   error item. The memory limit is written through cfg_write_enable and
//   cfg_write_data; the user must do so only while the block is idle, as the
//   block itself does not enforce it. The limit resets to 1 MiB. Throughput is
//   one character per cycle while the receiver does not stall, the back-end
//   parser updating its fields per character. An accepted character is written
//   into the two-entry queue, then taken through the parser into the output
//   register. When the receiver stalls, the output register holds its item,
//   the parser stops taking from the queue and the queue fills; in_stall
//   rises once both queue entries are occupied. Whitespace is consumed by the
//   front end. Reset clears all parser state and the queue; after an error
//   or the end of file, characters are taken and dropped until the next reset.
// ----------------------------------------------------------------------------
module intel_hex_record_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_enable,
    input  logic [31:0] cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [31:0] write_address,
    output logic [7:0]  write_data,
    output logic [31:0] start_address,
    output logic [31:0] extent_mark,
    output logic [2:0]  error_code
);
    import ihex_pkg::*;

    logic    q_full;
    logic    push;
    q_item_t push_item;
    logic    pop;
    logic    q_valid;
    q_item_t q_item;

    ihex_front u_front (
        .in_valid  (in_valid),
        .char_in   (char_in),
        .q_full    (q_full),
        .in_stall  (in_stall),
        .push      (push),
        .push_item (push_item)
    );

    ihex_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    ihex_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .q_valid          (q_valid),
        .q_item           (q_item),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .result_kind      (result_kind),
        .write_address    (write_address),
        .write_data       (write_data),
        .start_address    (start_address),
        .extent_mark      (extent_mark),
        .error_code       (error_code)
    );

endmodule

@@ design/ihex_front.sv @@
// ----------------------------------------------------------------------------
// ihex_front
// Takes characters, drops whitespace and classifies the rest as colon,
// hex digit (with its value) or other for the queue.
// ----------------------------------------------------------------------------
module ihex_front (
    input  logic             in_valid,
    input  logic [7:0]       char_in,
    input  logic             q_full,
    output logic             in_stall,
    output logic             push,
    output ihex_pkg::q_item_t push_item
);
    import ihex_pkg::*;

    logic is_space;
    logic is_digit;
    logic is_letter;

    always_comb
    begin
        is_space  = (char_in == 8'h20) || (char_in >= 8'h09 && char_in <= 8'h0d);
        is_digit  = (char_in >= 8'h30) && (char_in <= 8'h39);
        is_letter = ((char_in >= 8'h41) && (char_in <= 8'h46)) ||
                    ((char_in >= 8'h61) && (char_in <= 8'h66));
        push_item.digit = 4'd0;
        if (char_in == 8'h3a)
        begin
            push_item.cls = CLS_COLON;
        end
        else if (is_digit)
        begin
            push_item.cls   = CLS_HEX;
            push_item.digit = char_in[3:0];
        end
        else if (is_letter)
        begin
            push_item.cls   = CLS_HEX;
            push_item.digit = char_in[3:0] + 4'd9;
        end
        else
        begin
            push_item.cls = CLS_OTHER;
        end
    end

    assign in_stall = q_full;
    assign push     = in_valid && !q_full && !is_space;

endmodule

@@ design/ihex_queue.sv @@
// ----------------------------------------------------------------------------
// ihex_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module ihex_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ihex_pkg::q_item_t push_item,
    input  logic              pop,
    output logic              full,
    output logic              q_valid,
    output ihex_pkg::q_item_t q_item
);
    import ihex_pkg::*;

    q_item_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");

endmodule

@@ design/ihex_back.sv @@
// ----------------------------------------------------------------------------
// ihex_back
// Record parser: assembles hex fields, tracks base, start and extent,
// checks limit and checksum, and holds results in an output register.
// ----------------------------------------------------------------------------
module ihex_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_enable,
    input  logic [31:0]       cfg_write_data,
    input  logic              q_valid,
    input  ihex_pkg::q_item_t q_item,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        result_kind,
    output logic [31:0]       write_address,
    output logic [7:0]        write_data,
    output logic [31:0]       start_address,
    output logic [31:0]       extent_mark,
    output logic [2:0]        error_code
);
    import ihex_pkg::*;

    phase_t      phase_reg,          phase_next;
    logic [3:0]  digit_count_reg,    digit_count_next;
    logic [31:0] field_value_reg,    field_value_next;
    logic [7:0]  record_length_reg,  record_length_next;
    logic [31:0] record_address_reg, record_address_next;
    logic [7:0]  record_kind_reg,    record_kind_next;
    logic [7:0]  bytes_left_reg,     bytes_left_next;
    logic [31:0] base_address_reg,   base_address_next;
    logic [31:0] entry_address_reg,  entry_address_next;
    logic [7:0]  running_sum_reg,    running_sum_next;
    logic [31:0] high_water_reg,     high_water_next;
    logic        locked_reg,         locked_next;
    logic [31:0] memory_limit_reg;

    logic        out_valid_reg,      out_valid_next;
    logic [1:0]  kind_reg,           kind_next;
    logic [31:0] waddr_reg,          waddr_next;
    logic [7:0]  wdata_reg,          wdata_next;
    logic [31:0] start_reg,          start_next;
    logic [31:0] extent_reg,         extent_next;
    logic [2:0]  code_reg,           code_next;

    logic        emit;
    logic [31:0] fv_shift;
    logic [3:0]  dc_inc;
    logic [7:0]  sum_upd;
    logic [3:0]  needed;

    assign pop = q_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        phase_next          = phase_reg;
        digit_count_next    = digit_count_reg;
        field_value_next    = field_value_reg;
        record_length_next  = record_length_reg;
        record_address_next = record_address_reg;
        record_kind_next    = record_kind_reg;
        bytes_left_next     = bytes_left_reg;
        base_address_next   = base_address_reg;
        entry_address_next  = entry_address_reg;
        running_sum_next    = running_sum_reg;
        high_water_next     = high_water_reg;
        locked_next         = locked_reg;

        emit        = 1'b0;
        kind_next   = kind_reg;
        waddr_next  = waddr_reg;
        wdata_next  = wdata_reg;
        start_next  = start_reg;
        extent_next = extent_reg;
        code_next   = code_reg;

        fv_shift = {field_value_reg[27:0], q_item.digit};
        dc_inc   = digit_count_reg + 4'd1;
        sum_upd  = dc_inc[0] ? running_sum_reg : running_sum_reg + fv_shift[7:0];

        unique case (phase_reg)
            PH_ADDR:
                needed = 4'd4;
            PH_PAY_A, PH_PAY_B:
                needed = (record_kind_reg == REC_LIN_START) ? 4'd8 : 4'd4;
            default:
                needed = 4'd2;
        endcase

        if (pop && !locked_reg)
        begin
            if (phase_reg == PH_COLON)
            begin
                if (q_item.cls != CLS_COLON)
                begin
                    emit        = 1'b1;
                    locked_next = 1'b1;
                    kind_next   = KIND_ERROR;
                    code_next   = ERR_COLON;
                end
                else
                begin
                    phase_next       = PH_COUNT;
                    digit_count_next = 4'd0;
                    field_value_next = 32'd0;
                    running_sum_next = 8'd0;
                end
            end
            else if (q_item.cls != CLS_HEX)
            begin
                emit        = 1'b1;
                locked_next = 1'b1;
                kind_next   = KIND_ERROR;
                code_next   = ERR_NONHEX;
            end
            else if (dc_inc < needed)
            begin
                field_value_next = fv_shift;
                digit_count_next = dc_inc;
                running_sum_next = sum_upd;
            end
            else
            begin
                field_value_next = 32'd0;
                digit_count_next = 4'd0;
                running_sum_next = sum_upd;
                unique case (phase_reg)
                    PH_COUNT:
                    begin
                        record_length_next = fv_shift[7:0];
                        phase_next         = PH_ADDR;
                    end
                    PH_ADDR:
                    begin
                        record_address_next = base_address_reg + {16'd0, fv_shift[15:0]};
                        phase_next          = PH_TYPE;
                    end
                    PH_TYPE:
                    begin
                        record_kind_next = fv_shift[7:0];
                        if (fv_shift[7:0] == REC_DATA)
                        begin
                            bytes_left_next = record_length_reg;
                            phase_next = (record_length_reg == 8'd0) ? PH_CSUM : PH_DATA;
                        end
                        else if (fv_shift[7:0] == REC_EOF)
                        begin
                            phase_next = PH_CSUM;
                        end
                        else if (fv_shift[7:0] >= REC_SEGMENT &&
                                 fv_shift[7:0] <= REC_LIN_START)
                        begin
                            phase_next = PH_PAY_A;
                        end
                        else
                        begin
                            emit        = 1'b1;
                            locked_next = 1'b1;
                            kind_next   = KIND_ERROR;
                            code_next   = ERR_TYPE;
                        end
                    end
                    PH_DATA:
                    begin
                        if (record_address_reg >= memory_limit_reg)
                        begin
                            emit        = 1'b1;
                            locked_next = 1'b1;
                            kind_next   = KIND_ERROR;
                            code_next   = ERR_LIMIT;
                        end
                        else
                        begin
                            if (high_water_reg <= record_address_reg)
                            begin
                                high_water_next = record_address_reg + 32'd1;
                            end
                            record_address_next = record_address_reg + 32'd1;
                            bytes_left_next     = bytes_left_reg - 8'd1;
                            if (bytes_left_reg == 8'd1)
                            begin
                                phase_next = PH_CSUM;
                            end
                            emit      = 1'b1;
                            kind_next = KIND_WRITE;
                            waddr_next = record_address_reg;
                            wdata_next = fv_shift[7:0];
                            code_next  = ERR_COLON;
                        end
                    end
                    PH_PAY_A:
                    begin
                        phase_next = PH_CSUM;
                        case (record_kind_reg)
                            REC_SEGMENT:
                                base_address_next = {fv_shift[27:0], 4'd0};
                            REC_LINEAR:
                                base_address_next = {fv_shift[15:0], 16'd0};
                            REC_LIN_START:
                                entry_address_next = fv_shift;
                            default:
                            begin
                                entry_address_next = {fv_shift[27:0], 4'd0};
                                phase_next         = PH_PAY_B;
                            end
                        endcase
                    end
                    PH_PAY_B:
                    begin
                        entry_address_next = entry_address_reg + fv_shift;
                        phase_next         = PH_CSUM;
                    end
                    default:
                    begin
                        if (sum_upd != 8'd0)
                        begin
                            emit        = 1'b1;
                            locked_next = 1'b1;
                            kind_next   = KIND_ERROR;
                            code_next   = ERR_CHECKSUM;
                        end
                        else
                        begin
                            phase_next = PH_COLON;
                            if (record_kind_reg == REC_EOF)
                            begin
                                emit        = 1'b1;
                                locked_next = 1'b1;
                                kind_next   = KIND_DONE;
                                start_next  = entry_address_reg;
                                extent_next = high_water_reg;
                                code_next   = ERR_COLON;
                            end
                        end
                    end
                endcase
            end
        end

        // fields not belonging to the result kind read as zero
        if (emit)
        begin
            if (kind_next != KIND_WRITE)
            begin
                waddr_next = 32'd0;
                wdata_next = 8'd0;
            end
            if (kind_next != KIND_DONE)
            begin
                start_next  = 32'd0;
                extent_next = 32'd0;
            end
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_COLON;
            digit_count_reg    <= '0;
            field_value_reg    <= '0;
            record_length_reg  <= '0;
            record_address_reg <= '0;
            record_kind_reg    <= '0;
            bytes_left_reg     <= '0;
            base_address_reg   <= '0;
            entry_address_reg  <= '0;
            running_sum_reg    <= '0;
            high_water_reg     <= '0;
            locked_reg         <= 1'b0;
            memory_limit_reg   <= 32'h0010_0000;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            phase_reg          <= phase_next;
            digit_count_reg    <= digit_count_next;
            field_value_reg    <= field_value_next;
            record_length_reg  <= record_length_next;
            record_address_reg <= record_address_next;
            record_kind_reg    <= record_kind_next;
            bytes_left_reg     <= bytes_left_next;
            base_address_reg   <= base_address_next;
            entry_address_reg  <= entry_address_next;
            running_sum_reg    <= running_sum_next;
            high_water_reg     <= high_water_next;
            locked_reg         <= locked_next;
            out_valid_reg      <= out_valid_next;
            if (cfg_write_enable)
            begin
                memory_limit_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        waddr_reg  <= waddr_next;
        wdata_reg  <= wdata_next;
        start_reg  <= start_next;
        extent_reg <= extent_next;
        code_reg   <= code_next;
    end

    assign out_valid     = out_valid_reg;
    assign result_kind   = kind_reg;
    assign write_address = waddr_reg;
    assign write_data    = wdata_reg;
    assign start_address = start_reg;
    assign extent_mark   = extent_reg;
    assign error_code    = code_reg;

    a_locked_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        locked_reg |=> locked_reg)
        else $error("lock released without reset");

    a_final_result_locks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (kind_reg == KIND_DONE || kind_reg == KIND_ERROR) |-> locked_reg)
        else $error("done or error without lock");

    a_no_result_when_locked: assert property (@(posedge clk) disable iff (!rst_n)
        locked_reg |-> !emit)
        else $error("result produced while locked");

    a_code_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg != KIND_ERROR |-> code_reg == ERR_COLON)
        else $error("error code set on non-error result");

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the hex record parser. Streams well-formed hex text
// with random whitespace, letter case and record mix through the character
// channel under several pacing and stall patterns and memory limits, then
// closes the file with end of file or one randomly chosen fault. Every write,
// end-of-file and error item is predicted and compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ihex_pkg::*;

    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;

    localparam logic [31:0] LIMIT_AT_RESET = 32'd1048576;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [7:0]  data;
        logic [31:0] start;
        logic [31:0] extent;
        logic [2:0]  code;
    } parse_event_t;

    class record_tracker;
        phase_t       ph        = PH_COLON;
        logic [3:0]   digits    = '0;
        logic [31:0]  acc       = '0;
        logic [7:0]   rec_len   = '0;
        logic [31:0]  next_addr = '0;
        logic [7:0]   rec_kind  = '0;
        logic [7:0]   left      = '0;
        logic [31:0]  base      = '0;
        logic [31:0]  entry     = '0;
        logic [7:0]   sum       = '0;
        logic [31:0]  extent    = '0;
        bit           locked    = 1'b0;
        logic [31:0]  limit     = LIMIT_AT_RESET;
        parse_event_t awaited[$];
        int           failures  = 0;

        function void queue_event(logic [1:0] kind, logic [31:0] addr, logic [7:0] data,
                                  logic [31:0] start, logic [31:0] ext, logic [2:0] code);
            parse_event_t e;
            e.kind   = kind;
            e.addr   = addr;
            e.data   = data;
            e.start  = start;
            e.extent = ext;
            e.code   = code;
            awaited.push_back(e);
        endfunction

        function void raise(logic [2:0] code);
            locked = 1'b1;
            queue_event(KIND_ERROR, '0, '0, '0, '0, code);
        endfunction

        function logic [3:0] digits_wanted();
            if (ph == PH_ADDR)
                return 4'd4;
            if (ph == PH_PAY_A || ph == PH_PAY_B)
                return (rec_kind == REC_LIN_START) ? 4'd8 : 4'd4;
            return 4'd2;
        endfunction

        function void take_char(logic [7:0] c);
            logic [3:0]  d;
            logic [31:0] v;
            if (locked)
                return;
            if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
                return;
            if (ph == PH_COLON)
            begin
                if (c != CH_COLON)
                begin
                    raise(ERR_COLON);
                    return;
                end
                ph     = PH_COUNT;
                digits = '0;
                acc    = '0;
                sum    = '0;
                return;
            end
            if (c >= CH_ZERO && c <= CH_NINE)
                d = c[3:0];
            else if ((c >= CH_UPPER_A && c <= CH_UPPER_F) ||
                     (c >= CH_LOWER_A && c <= CH_LOWER_F))
                d = c[3:0] + 4'd9;
            else
            begin
                raise(ERR_NONHEX);
                return;
            end
            acc    = {acc[27:0], d};
            digits = digits + 4'd1;
            if (!digits[0])
                sum = sum + acc[7:0];
            if (digits < digits_wanted())
                return;
            v      = acc;
            digits = '0;
            acc    = '0;
            case (ph)
                PH_COUNT:
                begin
                    rec_len = v[7:0];
                    ph      = PH_ADDR;
                end
                PH_ADDR:
                begin
                    next_addr = base + {16'h0000, v[15:0]};
                    ph        = PH_TYPE;
                end
                PH_TYPE:
                begin
                    rec_kind = v[7:0];
                    if (rec_kind == REC_DATA)
                    begin
                        left = rec_len;
                        if (left == 0)
                            ph = PH_CSUM;
                        else
                            ph = PH_DATA;
                    end
                    else if (rec_kind == REC_EOF)
                        ph = PH_CSUM;
                    else if (rec_kind >= REC_SEGMENT && rec_kind <= REC_LIN_START)
                        ph = PH_PAY_A;
                    else
                        raise(ERR_TYPE);
                end
                PH_DATA:
                begin
                    if (next_addr >= limit)
                        raise(ERR_LIMIT);
                    else
                    begin
                        if (extent <= next_addr)
                            extent = next_addr + 32'd1;
                        queue_event(KIND_WRITE, next_addr, v[7:0], '0, '0, '0);
                        next_addr = next_addr + 32'd1;
                        left      = left - 8'd1;
                        if (left == 0)
                            ph = PH_CSUM;
                    end
                end
                PH_PAY_A:
                begin
                    if (rec_kind == REC_SEGMENT)
                        base = v << 4;
                    else if (rec_kind == REC_LINEAR)
                        base = v << 16;
                    else if (rec_kind == REC_LIN_START)
                        entry = v;
                    else
                    begin
                        entry = v << 4;
                        ph    = PH_PAY_B;
                    end
                    if (ph == PH_PAY_A)
                        ph = PH_CSUM;
                end
                PH_PAY_B:
                begin
                    entry = entry + v;
                    ph    = PH_CSUM;
                end
                default:
                begin
                    if (sum != 0)
                        raise(ERR_CHECKSUM);
                    else
                    begin
                        ph = PH_COLON;
                        if (rec_kind == REC_EOF)
                        begin
                            locked = 1'b1;
                            queue_event(KIND_DONE, '0, '0, entry, extent, '0);
                        end
                    end
                end
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
                failures++;
            end
        endfunction

        function void check_result(logic [1:0] kind, logic [31:0] addr, logic [7:0] data,
                                   logic [31:0] start, logic [31:0] ext, logic [2:0] code);
            parse_event_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: result_kind expected none, actual %0h", $time, kind);
                failures++;
                return;
            end
            want = awaited.pop_front();
            compare_field("result_kind", want.kind, kind);
            compare_field("write_address", want.addr, addr);
            compare_field("write_data", want.data, data);
            compare_field("start_address", want.start, start);
            compare_field("extent_mark", want.extent, ext);
            compare_field("error_code", want.code, code);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_write_enable;
    logic [31:0] cfg_write_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  char_in;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  result_kind;
    logic [31:0] write_address;
    logic [7:0]  write_data;
    logic [31:0] start_address;
    logic [31:0] extent_mark;
    logic [2:0]  error_code;

    record_tracker tracker;
    int            idle_pct   = 0;
    int            stall_pct  = 0;
    int            chars_sent = 0;
    logic [31:0]   gen_base   = '0;
    logic [31:0]   gen_limit  = LIMIT_AT_RESET;
    logic [7:0]    frame[$];

    intel_hex_record_parser_unit uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .char_in          (char_in),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .result_kind      (result_kind),
        .write_address    (write_address),
        .write_data       (write_data),
        .start_address    (start_address),
        .extent_mark      (extent_mark),
        .error_code       (error_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_result(result_kind, write_address, write_data, start_address,
                                 extent_mark, error_code);
    end

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return CH_ZERO + 8'(n);
        if ($urandom_range(1) == 0)
            return CH_UPPER_A + 8'(n - 4'd10);
        return CH_LOWER_A + 8'(n - 4'd10);
    endfunction

    function automatic logic [7:0] blank_char();
        int sel;
        sel = $urandom_range(5);
        if (sel == 5)
            return CH_SPACE;
        return CH_TAB + 8'(sel);
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [7:0] count_field(input logic [7:0] n);
        if ($urandom_range(3) == 0)
            return 8'($urandom);
        return n;
    endfunction

    function automatic void open_frame(input logic [7:0] n, input logic [15:0] addr,
                                       input logic [7:0] kind);
        frame.delete();
        frame.push_back(n);
        frame.push_back(addr[15:8]);
        frame.push_back(addr[7:0]);
        frame.push_back(kind);
    endfunction

    function automatic void add_random(input int n);
        repeat (n) frame.push_back(8'($urandom));
    endfunction

    task automatic send_char(input logic [7:0] c);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        char_in  <= c;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        tracker.take_char(c);
        chars_sent++;
    endtask

    task automatic send_digit(input logic [3:0] n);
        if ($urandom_range(15) == 0)
            send_char(blank_char());
        send_char(hex_char(n));
    endtask

    // checksum byte appended here, off by a random nonzero amount when asked
    task automatic put_record(input bit bad_sum);
        logic [7:0] total;
        total = '0;
        foreach (frame[i]) total = total + frame[i];
        if (bad_sum)
            total = total + 8'($urandom_range(1, 255));
        frame.push_back(8'h00 - total);
        if ($urandom_range(3) == 0)
            send_char(blank_char());
        send_char(CH_COLON);
        foreach (frame[i])
        begin
            send_digit(frame[i][7:4]);
            send_digit(frame[i][3:0]);
        end
        if ($urandom_range(1) == 0)
        begin
            send_char(CH_CR);
            send_char(CH_LF);
        end
    endtask

    task automatic base_record(input logic [7:0] kind, input logic [15:0] v);
        open_frame(count_field(8'd2), 16'($urandom), kind);
        frame.push_back(v[15:8]);
        frame.push_back(v[7:0]);
        put_record(1'b0);
        gen_base = (kind == REC_SEGMENT) ? {12'h000, v, 4'h0} : {v, 16'h0000};
    endtask

    task automatic entry_record(input logic [7:0] kind, input logic [31:0] w);
        open_frame(count_field(8'd4), 16'($urandom), kind);
        frame.push_back(w[31:24]);
        frame.push_back(w[23:16]);
        frame.push_back(w[15:8]);
        frame.push_back(w[7:0]);
        put_record(1'b0);
    endtask

    // keeps every write of the record below the current limit
    task automatic data_record(input int n, input bit bad_sum);
        if ({1'b0, gen_base} + 33'h1_0100 > {1'b0, gen_limit})
            base_record(REC_LINEAR, 16'h0000);
        open_frame(8'(n), 16'($urandom), REC_DATA);
        add_random(n);
        put_record(bad_sum);
    endtask

    task automatic random_record();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 66)
        begin
            n = $urandom_range(99);
            if (n == 0)
                n = $urandom_range(33, 255);
            else if (n < 8)
                n = 0;
            else if (n < 18)
                n = $urandom_range(16, 32);
            else
                n = $urandom_range(1, 8);
            data_record(n, 1'b0);
        end
        else if (pick < 74)
            base_record(REC_SEGMENT, 16'($urandom));
        else if (pick < 82)
            base_record(REC_LINEAR, 16'($urandom_range(0, 31)));
        else if (pick < 91)
            entry_record(REC_SEG_START, $urandom);
        else
            entry_record(REC_LIN_START, $urandom);
    endtask

    task automatic random_records(input int upto);
        while (chars_sent < upto) random_record();
    endtask

    // sender holds off until every expected item is out and the pipe is empty
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.awaited.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_limit(input logic [31:0] v);
        settle();
        @(negedge clk);
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= v;
        @(negedge clk);
        cfg_write_enable <= 1'b0;
        tracker.limit = v;
        gen_limit     = v;
    endtask

    task automatic directed_records();
        repeat (3) send_char(blank_char());
        open_frame(8'd4, 16'h0000, REC_DATA);
        frame.push_back(8'h00);
        frame.push_back(8'hFF);
        frame.push_back(8'h5A);
        frame.push_back(8'hA5);
        put_record(1'b0);
        open_frame(8'd0, 16'hFFFF, REC_DATA);
        put_record(1'b0);
        // last byte just below the limit, via segment and via linear base
        base_record(REC_SEGMENT, 16'hFFFF);
        open_frame(8'd1, 16'h000F, REC_DATA);
        add_random(1);
        put_record(1'b0);
        base_record(REC_LINEAR, 16'h000F);
        open_frame(8'd1, 16'hFFFF, REC_DATA);
        add_random(1);
        put_record(1'b0);
        base_record(REC_LINEAR, 16'h0000);
        entry_record(REC_SEG_START, 32'hFFFF_FFFF);
        entry_record(REC_LIN_START, 32'hFFFF_FFFF);
        open_frame(8'd16, 16'hFFF8, REC_DATA);
        add_random(16);
        put_record(1'b0);
    endtask

    // one terminating item per run: end of file or one kind of fault
    task automatic close_stream();
        int          how;
        int          n;
        int          k;
        logic [7:0]  c;
        logic [15:0] addr;
        how = $urandom_range(5);
        case (how)
            0:
            begin
                open_frame(($urandom_range(1) == 0) ? 8'h00 : 8'($urandom),
                           16'($urandom), REC_EOF);
                put_record(1'b0);
            end
            1:
            begin
                do c = 8'($urandom); while (c == CH_COLON || is_blank(c));
                send_char(c);
            end
            2:
            begin
                send_char(CH_COLON);
                repeat ($urandom_range(6)) send_digit(4'($urandom));
                if ($urandom_range(2) == 0)
                    c = CH_COLON;
                else
                    do c = 8'($urandom);
                    while (is_blank(c) || (c >= CH_ZERO && c <= CH_NINE) ||
                           (c >= CH_UPPER_A && c <= CH_UPPER_F) ||
                           (c >= CH_LOWER_A && c <= CH_LOWER_F));
                send_char(c);
            end
            3:
            begin
                base_record(REC_SEGMENT, 16'($urandom_range(0, 16'h0FFF)));
                addr = 16'($urandom);
                n    = $urandom_range(1, 8);
                k    = $urandom_range(0, n - 1);
                write_limit(gen_base + {16'h0000, addr} + 32'(k));
                open_frame(8'(n), addr, REC_DATA);
                add_random(n);
                put_record(1'b0);
            end
            4:
            begin
                open_frame(8'($urandom_range(0, 4)), 16'($urandom),
                           8'($urandom_range(6, 255)));
                add_random($urandom_range(0, 4));
                put_record(1'b0);
            end
            default:
            begin
                data_record($urandom_range(0, 8), 1'b1);
            end
        endcase
        // locked from here on: these items are taken and dropped
        send_char(8'h80 | 8'($urandom));
        repeat (40) send_char(8'($urandom));
    endtask

    initial
    begin
        tracker          = new;
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        char_in          = '0;
        cfg_write_enable = 1'b0;
        cfg_write_data   = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        directed_records();
        random_records(250);

        write_limit(32'h0000_0000);
        base_record(REC_SEGMENT, 16'($urandom));
        entry_record(REC_SEG_START, $urandom);
        entry_record(REC_LIN_START, $urandom);
        base_record(REC_LINEAR, 16'h0000);

        write_limit(32'hFFFF_FFFF);
        idle_pct  = 53;
        stall_pct = 0;
        if ($urandom_range(1) == 0)
        begin
            // top of the address space, last byte one below the limit
            base_record(REC_LINEAR, 16'hFFFF);
            open_frame(8'd15, 16'hFFF0, REC_DATA);
            add_random(15);
            put_record(1'b0);
            base_record(REC_LINEAR, 16'h0000);
        end
        random_records(480);

        write_limit($urandom_range(32'h0010_0000, 32'hFFFF_FFFF));
        idle_pct  = 0;
        stall_pct = 53;
        random_records(720);

        write_limit(LIMIT_AT_RESET);
        idle_pct  = 23;
        stall_pct = 23;
        random_records(940);
        close_stream();

        settle();
        if (tracker.failures == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
